// ===== rtl/core/lsq_pkg.sv =====
// Shared types and constants for the largest-square stream core.
package lsq_pkg;

    localparam int CHAR_W = 8;
    localparam int SIDE_W = 11;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [SIDE_W-1:0] SIDE_MAX = '1;

    // Register byte addresses on the configuration port.
    localparam logic [ADDR_W-1:0] ADDR_EMPTY_CHAR    = 4'h0;
    localparam logic [ADDR_W-1:0] ADDR_OBSTACLE_CHAR = 4'h4;
    localparam logic [ADDR_W-1:0] ADDR_ROW_WIDTH     = 4'h8;

    localparam logic [CHAR_W-1:0] RST_EMPTY_CHAR    = 8'd46;
    localparam logic [CHAR_W-1:0] RST_OBSTACLE_CHAR = 8'd111;
    localparam logic [SIDE_W-1:0] RST_ROW_WIDTH     = 11'd1024;

    typedef struct packed {
        logic [CHAR_W-1:0] empty_char;
        logic [CHAR_W-1:0] obstacle_char;
        logic [SIDE_W-1:0] row_width;
    } t_cfg;

endpackage

// ===== rtl/core/largest_square_dp_stream_core.sv =====
// Top level: streaming maximal-square core with line memory and APB configuration.
// Map characters arrive in raster order, one beat per cycle while o_stall is low, and each
// yields one result beat: the side of the largest empty square ending at that cell, the
// running maximum for the current map, and a flag for characters that are neither empty nor
// obstacle. The sustained rate is one beat per cycle while i_stall is low; an accepted beat
// passes through the compute stage registers into the output register.
// The previous row lives in a MAX_WIDTH-entry line memory: the entry is read when a beat is
// accepted and written back as it leaves the compute stage, with forwarding when the same
// column is read and written at once (row width one, or a map restart at column zero).
// The line memory needs no clearing pass; a map start begins in the first row, so no entry
// is read before it is written. Row width 0 acts as 1 and values above MAX_WIDTH as MAX_WIDTH.
module largest_square_dp_stream_core #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [lsq_pkg::CHAR_W-1:0]     i_cell_char,
    input  logic                           i_map_start,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [lsq_pkg::SIDE_W-1:0]     o_square_side,
    output logic [lsq_pkg::SIDE_W-1:0]     o_best_side,
    output logic                           o_bad_char,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lsq_pkg::ADDR_W-1:0]     paddr,
    input  logic [lsq_pkg::DATA_W-1:0]     pwdata,
    output logic [lsq_pkg::DATA_W-1:0]     prdata,
    output logic                           pready
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = (CW + 1 > lsq_pkg::SIDE_W) ? CW + 1 : lsq_pkg::SIDE_W;
    localparam logic [WW-1:0] MAX_W = WW'(MAX_WIDTH);

    lsq_pkg::t_cfg cfg;

    lsq_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Front state: position of the next beat.
    logic [CW-1:0]              r_col;
    logic                       r_first_row;

    // Compute stage registers.
    logic                       r_s1_valid;
    logic [CW-1:0]              r_s1_col;
    logic                       r_s1_first;
    logic                       r_s1_start;
    logic                       r_s1_end;
    logic [lsq_pkg::CHAR_W-1:0] r_s1_char;
    logic                       r_s1_fwd;
    logic [lsq_pkg::SIDE_W-1:0] r_s1_fwd_data;
    logic [lsq_pkg::SIDE_W-1:0] r_mem_q;

    // Running neighbor values and maximum.
    logic [lsq_pkg::SIDE_W-1:0] r_left;
    logic [lsq_pkg::SIDE_W-1:0] r_diag;
    logic [lsq_pkg::SIDE_W-1:0] r_best;

    // Output register.
    logic                       r_out_valid;
    logic [lsq_pkg::SIDE_W-1:0] r_out_side;
    logic [lsq_pkg::SIDE_W-1:0] r_out_best;
    logic                       r_out_bad;

    logic [lsq_pkg::SIDE_W-1:0] r_row_mem [MAX_WIDTH];

    logic                       s1_adv;
    logic                       accept;
    logic [WW-1:0]              eff_w;
    logic [WW-1:0]              row_w_ext;
    logic [CW-1:0]              col0;
    logic                       first0;
    logic                       end0;
    logic [WW-1:0]              col0_inc;

    logic [lsq_pkg::SIDE_W-1:0] up;
    logic [lsq_pkg::SIDE_W-1:0] left_eff;
    logic [lsq_pkg::SIDE_W-1:0] diag_eff;
    logic [lsq_pkg::SIDE_W-1:0] best_eff;
    logic [lsq_pkg::SIDE_W-1:0] min_a;
    logic [lsq_pkg::SIDE_W-1:0] min3;
    logic [lsq_pkg::SIDE_W:0]   inc;
    logic [lsq_pkg::SIDE_W-1:0] n_side;
    logic [lsq_pkg::SIDE_W-1:0] n_best;
    logic                       n_bad;

    assign s1_adv  = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_s1_valid && !s1_adv;
    assign accept  = i_valid && !o_stall;

    // Front: column and first-row flag of the incoming beat.
    always_comb begin
        row_w_ext = WW'(cfg.row_width);
        if (row_w_ext == '0) begin
            eff_w = WW'(1);
        end else if (row_w_ext > MAX_W) begin
            eff_w = MAX_W;
        end else begin
            eff_w = row_w_ext;
        end
        col0     = i_map_start ? '0 : r_col;
        first0   = i_map_start ? 1'b1 : r_first_row;
        col0_inc = WW'(col0) + WW'(1);
        end0     = (col0_inc >= eff_w);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_first_row <= 1'b1;
        end else if (accept) begin
            r_col       <= end0 ? '0 : col0_inc[CW-1:0];
            r_first_row <= end0 ? 1'b0 : first0;
        end
    end

    // Line memory: read on accept, write back from the compute stage.
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_row_mem[r_s1_col] <= n_side;
        end
        if (accept) begin
            r_mem_q <= r_row_mem[col0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_col      <= col0;
            r_s1_first    <= first0;
            r_s1_start    <= i_map_start;
            r_s1_end      <= end0;
            r_s1_char     <= i_cell_char;
            // The memory returns the old value when the stage ahead writes the same entry.
            r_s1_fwd      <= r_s1_valid && (r_s1_col == col0);
            r_s1_fwd_data <= n_side;
        end
    end

    // Compute stage.
    always_comb begin
        left_eff = r_s1_start ? '0 : r_left;
        diag_eff = r_s1_start ? '0 : r_diag;
        best_eff = r_s1_start ? '0 : r_best;
        if (r_s1_first) begin
            up = '0;
        end else if (r_s1_fwd) begin
            up = r_s1_fwd_data;
        end else begin
            up = r_mem_q;
        end
        min_a = (up < diag_eff) ? up : diag_eff;
        min3  = (min_a < left_eff) ? min_a : left_eff;
        inc   = {1'b0, min3} + {{lsq_pkg::SIDE_W{1'b0}}, 1'b1};
        n_bad = 1'b0;
        if (r_s1_char == cfg.obstacle_char) begin
            n_side = '0;
        end else if (r_s1_char == cfg.empty_char) begin
            if (r_s1_first || (r_s1_col == '0)) begin
                n_side = lsq_pkg::SIDE_W'(1);
            end else if (inc[lsq_pkg::SIDE_W]) begin
                n_side = lsq_pkg::SIDE_MAX;
            end else begin
                n_side = inc[lsq_pkg::SIDE_W-1:0];
            end
        end else begin
            n_side = '0;
            n_bad  = 1'b1;
        end
        n_best = (n_side > best_eff) ? n_side : best_eff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_diag <= '0;
            r_best <= '0;
        end else if (s1_adv) begin
            r_left <= r_s1_end ? '0 : n_side;
            r_diag <= r_s1_end ? '0 : up;
            r_best <= n_best;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_side <= n_side;
            r_out_best <= n_best;
            r_out_bad  <= n_bad;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_square_side = r_out_side;
    assign o_best_side   = r_out_best;
    assign o_bad_char    = r_out_bad;

endmodule

// ===== rtl/core/lsq_regs.sv =====
// APB register file holding the character codes and the row width.
module lsq_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lsq_pkg::ADDR_W-1:0]     paddr,
    input  logic [lsq_pkg::DATA_W-1:0]     pwdata,
    output logic [lsq_pkg::DATA_W-1:0]     prdata,
    output logic                           pready,
    output lsq_pkg::t_cfg                  o_cfg
);

    lsq_pkg::t_cfg r_cfg;
    logic          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.empty_char    <= lsq_pkg::RST_EMPTY_CHAR;
            r_cfg.obstacle_char <= lsq_pkg::RST_OBSTACLE_CHAR;
            r_cfg.row_width     <= lsq_pkg::RST_ROW_WIDTH;
        end else if (wr_en) begin
            case (paddr)
                lsq_pkg::ADDR_EMPTY_CHAR:    r_cfg.empty_char    <= pwdata[lsq_pkg::CHAR_W-1:0];
                lsq_pkg::ADDR_OBSTACLE_CHAR: r_cfg.obstacle_char <= pwdata[lsq_pkg::CHAR_W-1:0];
                lsq_pkg::ADDR_ROW_WIDTH:     r_cfg.row_width     <= pwdata[lsq_pkg::SIDE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (paddr)
            lsq_pkg::ADDR_EMPTY_CHAR:
                prdata = {{(lsq_pkg::DATA_W-lsq_pkg::CHAR_W){1'b0}}, r_cfg.empty_char};
            lsq_pkg::ADDR_OBSTACLE_CHAR:
                prdata = {{(lsq_pkg::DATA_W-lsq_pkg::CHAR_W){1'b0}}, r_cfg.obstacle_char};
            lsq_pkg::ADDR_ROW_WIDTH:
                prdata = {{(lsq_pkg::DATA_W-lsq_pkg::SIDE_W){1'b0}}, r_cfg.row_width};
            default: prdata = '0;
        endcase
    end

endmodule

// ===== dv/largest_square_dp_stream_core_tb.sv =====
// Self-checking testbench for the largest-square stream core: directed maps, then random maps.
`timescale 1ns / 1ps

module largest_square_dp_stream_core_tb;

    localparam int LINE_DEPTH    = 1024;
    localparam int RANDOM_CELLS  = 700;
    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic [lsq_pkg::SIDE_W-1:0] square_side;
        logic [lsq_pkg::SIDE_W-1:0] best_side;
        logic                       bad_char;
    } t_cell_result;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_valid;
    logic                        o_stall;
    logic [lsq_pkg::CHAR_W-1:0]  i_cell_char;
    logic                        i_map_start;
    logic                        o_valid;
    logic                        i_stall;
    logic [lsq_pkg::SIDE_W-1:0]  o_square_side;
    logic [lsq_pkg::SIDE_W-1:0]  o_best_side;
    logic                        o_bad_char;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [lsq_pkg::ADDR_W-1:0]  paddr;
    logic [lsq_pkg::DATA_W-1:0]  pwdata;
    logic [lsq_pkg::DATA_W-1:0]  prdata;
    logic                        pready;

    // Mirror of the block: configuration, line store and neighbor registers.
    lsq_pkg::t_cfg               map_cfg;
    logic [lsq_pkg::SIDE_W-1:0]  line_mem [LINE_DEPTH];
    bit                          line_written [LINE_DEPTH];
    logic [lsq_pkg::SIDE_W-1:0]  prev_left;
    logic [lsq_pkg::SIDE_W-1:0]  prev_diag;
    logic [9:0]                  col_pos;
    bit                          first_row;
    logic [lsq_pkg::SIDE_W-1:0]  map_best;

    t_cell_result                pending_results [$];
    t_cell_result                head_result;
    int unsigned                 mismatches;
    int unsigned                 idle_cycles;
    bit                          tx_pauses;
    bit                          rx_pauses;

    largest_square_dp_stream_core #(
        .MAX_WIDTH(LINE_DEPTH)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_cell_char(i_cell_char),
        .i_map_start(i_map_start),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_square_side(o_square_side),
        .o_best_side(o_best_side),
        .o_bad_char(o_bad_char),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic void log_mismatch(string what, int unsigned exp_v, int unsigned act_v);
        if (mismatches < MAX_REPORTS) begin
            $display("%0t: %0s: expected %0d, got %0d", $realtime, what, exp_v, act_v);
        end
        mismatches++;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic int unsigned active_width();
        int unsigned w;
        w = 32'(map_cfg.row_width);
        if (w == 0) w = 1;
        if (w > LINE_DEPTH) w = LINE_DEPTH;
        return w;
    endfunction

    function automatic logic [lsq_pkg::DATA_W-1:0] reg_value(
        logic [lsq_pkg::ADDR_W-1:0] addr);
        case (addr)
            lsq_pkg::ADDR_EMPTY_CHAR:    return lsq_pkg::DATA_W'(map_cfg.empty_char);
            lsq_pkg::ADDR_OBSTACLE_CHAR: return lsq_pkg::DATA_W'(map_cfg.obstacle_char);
            default:                     return lsq_pkg::DATA_W'(map_cfg.row_width);
        endcase
    endfunction

    // Advances the mirrored DP state by one cell and queues the result it must produce.
    function automatic void dp_update_cell(logic [lsq_pkg::CHAR_W-1:0] ch, logic start);
        t_cell_result r;
        int unsigned  up;
        int unsigned  side;
        int unsigned  m;
        int unsigned  w;
        w = active_width();
        if (start) begin
            col_pos = '0;
            prev_left = '0;
            prev_diag = '0;
            first_row = 1'b1;
            map_best = '0;
        end
        up = first_row ? 0 : 32'(line_mem[col_pos]);
        side = 0;
        r.bad_char = 1'b0;
        if (ch == map_cfg.obstacle_char) begin
            side = 0;
        end else if (ch == map_cfg.empty_char) begin
            if (first_row || col_pos == 0) begin
                side = 1;
            end else begin
                m = (up < 32'(prev_diag)) ? up : 32'(prev_diag);
                m = (m < 32'(prev_left)) ? m : 32'(prev_left);
                side = m + 1;
                if (side > 32'(lsq_pkg::SIDE_MAX)) side = 32'(lsq_pkg::SIDE_MAX);
            end
        end else begin
            r.bad_char = 1'b1;
        end
        if (side > 32'(map_best)) map_best = lsq_pkg::SIDE_W'(side);
        prev_diag = lsq_pkg::SIDE_W'(up);
        prev_left = lsq_pkg::SIDE_W'(side);
        line_mem[col_pos] = lsq_pkg::SIDE_W'(side);
        line_written[col_pos] = 1'b1;
        if (int'(col_pos) + 1 >= int'(w)) begin
            col_pos = '0;
            first_row = 1'b0;
            prev_left = '0;
            prev_diag = '0;
        end else begin
            col_pos = col_pos + 10'd1;
        end
        r.square_side = lsq_pkg::SIDE_W'(side);
        r.best_side = map_best;
        pending_results.push_back(r);
    endfunction

    // Sends one cell beat. A cell that would read a line-store entry never written since
    // reset is turned into a map start, which keeps the stimulus inside the contract.
    task automatic feed_cell(input logic [lsq_pkg::CHAR_W-1:0] ch, input logic start);
        int unsigned gap;
        logic        s;
        s = start;
        if (!s && !first_row && !line_written[col_pos]) s = 1'b1;
        gap = tx_pauses ? pick_gap() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_cell_char <= ch;
        i_map_start <= s;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        dp_update_cell(ch, s);
    endtask

    // Drops valid and waits until every pending result has been checked.
    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic read_reg(input logic [lsq_pkg::ADDR_W-1:0] addr,
                            output logic [lsq_pkg::DATA_W-1:0] data);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        data = prdata;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_reg(input logic [lsq_pkg::ADDR_W-1:0] addr);
        logic [lsq_pkg::DATA_W-1:0] rd;
        read_reg(addr, rd);
        if (rd !== reg_value(addr)) log_mismatch($sformatf("register 0x%0h readback", addr),
                                                 reg_value(addr), rd);
    endtask

    // Writes a register while the block is idle, updates the mirror and reads it back.
    task automatic program_reg(input logic [lsq_pkg::ADDR_W-1:0] addr,
                               input logic [lsq_pkg::DATA_W-1:0] data);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (addr)
            lsq_pkg::ADDR_EMPTY_CHAR:    map_cfg.empty_char = data[lsq_pkg::CHAR_W-1:0];
            lsq_pkg::ADDR_OBSTACLE_CHAR: map_cfg.obstacle_char = data[lsq_pkg::CHAR_W-1:0];
            lsq_pkg::ADDR_ROW_WIDTH:     map_cfg.row_width = data[lsq_pkg::SIDE_W-1:0];
            default:                     ;
        endcase
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        check_reg(addr);
    endtask

    function automatic logic [lsq_pkg::CHAR_W-1:0] pick_char(bit noisy);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (noisy && r < 50) return lsq_pkg::CHAR_W'($urandom_range(0, 255));
        r = $urandom_range(0, 99);
        if (r < 65) return map_cfg.empty_char;
        if (r < 90) return map_cfg.obstacle_char;
        return lsq_pkg::CHAR_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [lsq_pkg::SIDE_W-1:0] pick_width();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return lsq_pkg::SIDE_W'($urandom_range(1, 8));
        if (r < 80) return lsq_pkg::SIDE_W'($urandom_range(9, 40));
        if (r < 93) return lsq_pkg::SIDE_W'($urandom_range(41, 200));
        if (r < 96) return '0;
        if (r < 98) return lsq_pkg::SIDE_W'(LINE_DEPTH);
        return lsq_pkg::SIDE_W'($urandom_range(LINE_DEPTH + 1, 2047));
    endfunction

    // One map: mostly a well-formed raster of whole rows, sometimes noise with stray starts.
    task automatic run_map(input int budget, input bit fresh, output int count);
        bit well_formed;
        int rows;
        int n;
        logic start;
        well_formed = $urandom_range(0, 99) < 85;
        rows = $urandom_range(1, 6);
        n = rows * int'(active_width());
        if (n > budget) n = budget;
        for (int i = 0; i < n; i++) begin
            if (well_formed) start = fresh && i == 0;
            else start = $urandom_range(0, 19) == 0;
            feed_cell(pick_char(!well_formed), start);
        end
        count = n;
    endtask

    task automatic test_register_defaults();
        check_reg(lsq_pkg::ADDR_EMPTY_CHAR);
        check_reg(lsq_pkg::ADDR_OBSTACLE_CHAR);
        check_reg(lsq_pkg::ADDR_ROW_WIDTH);
    endtask

    // First row, first column, an interior cell, an obstacle and a bad character.
    task automatic test_edge_cells();
        logic [lsq_pkg::CHAR_W-1:0] cells [9];
        cells = '{lsq_pkg::RST_EMPTY_CHAR, lsq_pkg::RST_EMPTY_CHAR, lsq_pkg::RST_EMPTY_CHAR,
                  lsq_pkg::RST_EMPTY_CHAR, lsq_pkg::RST_EMPTY_CHAR, lsq_pkg::RST_EMPTY_CHAR,
                  8'h00, lsq_pkg::RST_OBSTACLE_CHAR, lsq_pkg::RST_EMPTY_CHAR};
        wait_idle();
        program_reg(lsq_pkg::ADDR_ROW_WIDTH, 3);
        for (int i = 0; i < 9; i++) feed_cell(cells[i], i == 0);
    endtask

    // A map start in the middle of a row restarts the column and clears the maximum.
    task automatic test_map_restart();
        feed_cell(lsq_pkg::RST_EMPTY_CHAR, 1'b1);
        feed_cell(lsq_pkg::RST_EMPTY_CHAR, 1'b0);
        feed_cell(lsq_pkg::RST_EMPTY_CHAR, 1'b1);
        feed_cell(lsq_pkg::RST_EMPTY_CHAR, 1'b0);
    endtask

    task automatic test_char_codes();
        wait_idle();
        program_reg(lsq_pkg::ADDR_EMPTY_CHAR, 0);
        program_reg(lsq_pkg::ADDR_OBSTACLE_CHAR, 255);
        feed_cell(8'h00, 1'b1);
        feed_cell(8'hFF, 1'b0);
        feed_cell(lsq_pkg::RST_EMPTY_CHAR, 1'b0);
        // With equal codes the obstacle meaning wins.
        wait_idle();
        program_reg(lsq_pkg::ADDR_EMPTY_CHAR, 7);
        program_reg(lsq_pkg::ADDR_OBSTACLE_CHAR, 7);
        feed_cell(8'd7, 1'b1);
        feed_cell(8'hFF, 1'b0);
        wait_idle();
        program_reg(lsq_pkg::ADDR_EMPTY_CHAR, lsq_pkg::DATA_W'(lsq_pkg::RST_EMPTY_CHAR));
        program_reg(lsq_pkg::ADDR_OBSTACLE_CHAR,
                    lsq_pkg::DATA_W'(lsq_pkg::RST_OBSTACLE_CHAR));
    endtask

    task automatic test_width_limits();
        wait_idle();
        program_reg(lsq_pkg::ADDR_ROW_WIDTH, 0);
        feed_cell(lsq_pkg::RST_EMPTY_CHAR, 1'b1);
        feed_cell(lsq_pkg::RST_EMPTY_CHAR, 1'b0);
        wait_idle();
        program_reg(lsq_pkg::ADDR_ROW_WIDTH, 2047);
        feed_cell(lsq_pkg::RST_EMPTY_CHAR, 1'b1);
        feed_cell(lsq_pkg::RST_EMPTY_CHAR, 1'b0);
        // Shrinking the width below the current column makes the next cell end the row.
        wait_idle();
        program_reg(lsq_pkg::ADDR_ROW_WIDTH, 4);
        for (int i = 0; i < 3; i++) feed_cell(lsq_pkg::RST_EMPTY_CHAR, i == 0);
        wait_idle();
        program_reg(lsq_pkg::ADDR_ROW_WIDTH, 2);
        for (int i = 0; i < 3; i++) feed_cell(lsq_pkg::RST_EMPTY_CHAR, 1'b0);
    endtask

    task automatic test_random_maps();
        int  sent;
        int  budget;
        int  n;
        bit  fresh;
        bit  first_phase;
        sent = 0;
        first_phase = 1'b1;
        while (sent < RANDOM_CELLS) begin
            wait_idle();
            tx_pauses = $urandom_range(0, 3) != 0;
            rx_pauses = $urandom_range(0, 3) != 0;
            if (first_phase || $urandom_range(0, 1) == 1) begin
                program_reg(lsq_pkg::ADDR_EMPTY_CHAR, $urandom_range(0, 255));
            end
            if (first_phase || $urandom_range(0, 1) == 1) begin
                if ($urandom_range(0, 9) == 0)
                    program_reg(lsq_pkg::ADDR_OBSTACLE_CHAR,
                                lsq_pkg::DATA_W'(map_cfg.empty_char));
                else program_reg(lsq_pkg::ADDR_OBSTACLE_CHAR, $urandom_range(0, 255));
            end
            if (first_phase || $urandom_range(0, 2) != 0)
                program_reg(lsq_pkg::ADDR_ROW_WIDTH, lsq_pkg::DATA_W'(pick_width()));
            first_phase = 1'b0;
            budget = $urandom_range(30, 120);
            fresh = $urandom_range(0, 4) != 0;
            while (budget > 0) begin
                run_map(budget, fresh, n);
                budget -= n;
                sent += n;
                fresh = 1'b1;
                if ($urandom_range(0, 9) == 0) wait_idle();
            end
        end
    endtask

    // Receiver back-pressure: runs of stall and no-stall of random length.
    initial begin
        int unsigned run_left;
        bit          stalled;
        run_left = 0;
        stalled = 1'b0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (run_left > 0) begin
                run_left--;
            end else if ($urandom_range(0, 3) == 0) begin
                stalled = 1'b1;
                run_left = pick_gap();
            end else begin
                stalled = 1'b0;
                run_left = $urandom_range(0, 6);
            end
            i_stall <= rx_pauses && stalled;
        end
    end

    // Compares each accepted result beat with the oldest pending one.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                log_mismatch("result beat with nothing pending", 0, 32'(o_square_side));
            end else begin
                head_result = pending_results.pop_front();
                if (o_square_side !== head_result.square_side)
                    log_mismatch("square_side", 32'(head_result.square_side),
                                 32'(o_square_side));
                if (o_best_side !== head_result.best_side)
                    log_mismatch("best_side", 32'(head_result.best_side), 32'(o_best_side));
                if (o_bad_char !== head_result.bad_char)
                    log_mismatch("bad_char", 32'(head_result.bad_char), 32'(o_bad_char));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || (psel && penable)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("largest_square_dp_stream_core_tb: done, errors");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_cell_char = '0;
        i_map_start = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        tx_pauses = 1'b0;
        rx_pauses = 1'b0;
        mismatches = 0;
        idle_cycles = 0;
        map_cfg = '{lsq_pkg::RST_EMPTY_CHAR, lsq_pkg::RST_OBSTACLE_CHAR,
                    lsq_pkg::RST_ROW_WIDTH};
        col_pos = '0;
        prev_left = '0;
        prev_diag = '0;
        first_row = 1'b1;
        map_best = '0;
        for (int i = 0; i < LINE_DEPTH; i++) line_written[i] = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_register_defaults();
        test_edge_cells();
        tx_pauses = 1'b1;
        rx_pauses = 1'b1;
        test_map_restart();
        test_char_codes();
        test_width_limits();
        test_random_maps();

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("largest_square_dp_stream_core_tb: done, clean");
        end else begin
            $display("largest_square_dp_stream_core_tb: done, errors");
        end
        $finish;
    end

endmodule
